// ===== design/circular_fifo_queue_assert.svh =====
// Assertion macros for the circular FIFO queue.
// Used by the top level; the bodies compile away when SYNTHESIS is defined.
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define CFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFQ_ASSERT_NOW(label, ante, cons, msg)
`define CFQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/cfq_pkg.sv =====
// Shared constants, codes and types of the circular FIFO queue.
// No dependencies; imported by every module of the block.
`default_nettype none
package cfq_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/circular_fifo_queue.sv =====
// Circular FIFO queue: a chain of cfq_cell instances plus command decode,
// count, capacity register and result register. Depends on cfq_pkg and cfq_cell.
`default_nettype none
`include "circular_fifo_queue_assert.svh"
// Takes one command (push, pop or peek) per clock and returns one result per
// command through a result register; a command is taken while the previous
// result waits, as long as the result side is not stalling. The entries sit
// in a row of cells with the oldest in the first cell: a pop shifts every
// cell toward the head at once, a push fills the first free cell. Writing
// the capacity register empties the queue; capacity 0 acts as 1 and values
// above the built depth act as the depth.
module circular_fifo_queue
  import cfq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command,
  input  wire logic [DATA_W-1:0] value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      read_value,
  output logic [1:0]             status,
  output logic [OCC_W-1:0]       occupancy,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_data
);

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  eff_cap;
  logic              accept;
  logic              cfg_write;
  cell_ctrl_t        ctl;
  logic [DATA_W-1:0] rd;
  status_t           st;
  logic [DATA_W-1:0] data_vec [DEPTH];
  logic [DEPTH-1:0]  full_vec;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  always_comb begin
    rd         = '1;
    st         = ST_OK;
    count_next = count;
    ctl.push   = 1'b0;
    ctl.pop    = 1'b0;
    ctl.clear  = cfg_write;
    case (command)
      CMD_PUSH: begin
        if (count >= eff_cap) begin
          st = ST_OVERFLOW;
        end else begin
          ctl.push   = accept;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          st = ST_UNDERFLOW;
        end else begin
          rd         = data_vec[0];
          ctl.pop    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (count == '0) begin
          st = ST_UNDERFLOW;
        end else begin
          rd = data_vec[0];
        end
      end
      default: begin
        rd = '1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd;
      status     <= st;
      occupancy  <= OCC_W'(count_next);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_full;
    logic [DATA_W-1:0] next_data;
    logic              next_full;

    if (i == 0) begin : g_first
      assign prev_full = 1'b1;
    end else begin : g_mid
      assign prev_full = full_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = '1;
      assign next_full = 1'b0;
    end else begin : g_inner
      assign next_data = data_vec[i+1];
      assign next_full = full_vec[i+1];
    end

    cfq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .push_data (value),
      .prev_full (prev_full),
      .next_data (next_data),
      .next_full (next_full),
      .data      (data_vec[i]),
      .full      (full_vec[i])
    );
  end

  `CFQ_ASSERT_NOW(a_cells_match_count, 1'b1, $countones(full_vec) == 32'(count), "occupied cells differ from count")
  `CFQ_ASSERT_NOW(a_count_in_cap, 1'b1, count <= eff_cap, "count above capacity")
  `CFQ_ASSERT_NEXT(a_pop_drops_one, accept && !cfg_write && command == CMD_POP && count != '0, count == $past(count) - CNT_W'(1), "pop did not drop count")
  `CFQ_ASSERT_NOW(a_underflow_neg_one, out_valid && status == ST_UNDERFLOW, read_value == '1, "underflow result not -1")

endmodule
`default_nettype wire

// ===== design/cfq_cell.sv =====
// One storage cell of the queue chain: a word and its occupied flag.
// Depends on cfq_pkg for widths and the cell control struct.
`default_nettype none
module cfq_cell
  import cfq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctl,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              prev_full,
  input  wire logic [DATA_W-1:0] next_data,
  input  wire logic              next_full,
  output logic      [DATA_W-1:0] data,
  output logic                   full
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      full <= 1'b0;
    end else if (ctl.pop) begin
      // shift toward the head of the chain
      full <= next_full;
    end else if (ctl.push && !full && prev_full) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= next_data;
    end else if (ctl.push && !full && prev_full) begin
      // first free cell takes the new item
      data <= push_data;
    end
  end

endmodule
`default_nettype wire
